// File: rtl/pod_pkg.sv
// Shared types, constants, microcode table and key helper for the password decoder.
`timescale 1ns / 1ps

package pod_pkg;

	// Printable range '!'..'~'
	localparam logic [7:0] FIRST_PRINT = 8'd33;
	localparam logic [7:0] PRINT_RANGE = 8'd94;
	localparam int unsigned CharW = 7;
	localparam int unsigned StepW = 3;

	typedef logic [StepW-1:0] step_t;
	typedef logic [CharW-1:0] char_t;

	// Microcode step addresses
	localparam step_t STEP_LOAD   = 3'd0;
	localparam step_t STEP_INIT   = 3'd1;
	localparam step_t STEP_READ   = 3'd2;
	localparam step_t STEP_CALC   = 3'd3;
	localparam step_t STEP_EMIT   = 3'd4;
	localparam step_t STEP_NEXT   = 3'd5;
	localparam step_t STEP_FLUSH  = 3'd6;
	localparam step_t STEP_SINGLE = 3'd7;

	// Datapath operations
	typedef enum logic [2:0] {
		OP_NONE,
		OP_LOAD,
		OP_INIT,
		OP_READ,
		OP_CALC,
		OP_EMIT,
		OP_FLUSH,
		OP_SINGLE
	} op_t;

	// Jump conditions
	typedef enum logic [2:0] {
		C_NEVER,
		C_ALWAYS,
		C_NOT_FIN,
		C_SINGLE,
		C_HIT,
		C_MORE
	} cond_t;

	typedef struct packed {
		logic  in_ready;
		logic  wait_out;
		op_t   op;
		cond_t cond;
		step_t target;
	} ctrl_word_t;

	typedef struct packed {
		logic fin;
		logic single;
		logic hit;
		logic lastc;
		logic obusy;
	} dp_status_t;

	// Control store: one word per step
	function automatic ctrl_word_t ucode_rom(input step_t step);
		ctrl_word_t cw;
		cw = '{in_ready: 1'b0, wait_out: 1'b0, op: OP_NONE, cond: C_NEVER, target: STEP_LOAD};
		unique case (step)
			STEP_LOAD: begin
				cw = '{in_ready: 1'b1, wait_out: 1'b0, op: OP_LOAD, cond: C_NOT_FIN,
					target: STEP_LOAD};
			end
			STEP_INIT: begin
				cw = '{in_ready: 1'b0, wait_out: 1'b0, op: OP_INIT, cond: C_SINGLE,
					target: STEP_SINGLE};
			end
			STEP_READ: begin
				cw = '{in_ready: 1'b0, wait_out: 1'b0, op: OP_READ, cond: C_NEVER,
					target: STEP_LOAD};
			end
			STEP_CALC: begin
				cw = '{in_ready: 1'b0, wait_out: 1'b0, op: OP_CALC, cond: C_NEVER,
					target: STEP_LOAD};
			end
			STEP_EMIT: begin
				cw = '{in_ready: 1'b0, wait_out: 1'b1, op: OP_EMIT, cond: C_HIT,
					target: STEP_LOAD};
			end
			STEP_NEXT: begin
				cw = '{in_ready: 1'b0, wait_out: 1'b0, op: OP_NONE, cond: C_MORE,
					target: STEP_READ};
			end
			STEP_FLUSH: begin
				cw = '{in_ready: 1'b0, wait_out: 1'b1, op: OP_FLUSH, cond: C_ALWAYS,
					target: STEP_LOAD};
			end
			STEP_SINGLE: begin
				cw = '{in_ready: 1'b0, wait_out: 1'b1, op: OP_SINGLE, cond: C_ALWAYS,
					target: STEP_LOAD};
			end
		endcase
		return cw;
	endfunction

	// Key character to key value: (c - '!') mod 94
	function automatic char_t reduce_key(input char_t c);
		logic [7:0] v;
		v = {1'b0, c} - FIRST_PRINT;
		if ({1'b0, c} < FIRST_PRINT) begin
			v = {1'b0, c} + PRINT_RANGE - FIRST_PRINT;
		end else if (v == PRINT_RANGE) begin
			v = 8'd0;
		end
		return v[CharW-1:0];
	endfunction

endpackage

// File: rtl/pod_seq.sv
// Microcode sequencer: step counter, control store lookup and conditional jumps.
`timescale 1ns / 1ps

module pod_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  pod_pkg::dp_status_t st,
	output pod_pkg::ctrl_word_t cw
);

	pod_pkg::step_t step_q;
	logic           take;
	logic           stall;

	// Fetch the control word of the current step
	assign cw = pod_pkg::ucode_rom(step_q);

	// Hold while the step waits on a full output register
	assign stall = cw.wait_out && st.obusy;

	// Evaluate the jump condition
	always_comb begin
		take = 1'b0;
		unique case (cw.cond)
			pod_pkg::C_NEVER:   take = 1'b0;
			pod_pkg::C_ALWAYS:  take = 1'b1;
			pod_pkg::C_NOT_FIN: take = !st.fin;
			pod_pkg::C_SINGLE:  take = st.single;
			pod_pkg::C_HIT:     take = st.hit;
			pod_pkg::C_MORE:    take = !st.lastc;
			default:            take = 1'b0;
		endcase
	end

	// Advance, jump or hold
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= pod_pkg::STEP_LOAD;
		end else if (!stall) begin
			if (take) begin
				step_q <= cw.target;
			end else begin
				step_q <= step_q + pod_pkg::StepW'(1);
			end
		end
	end

endmodule

// File: rtl/pod_dp.sv
// Datapath: key and body stores, load counters, key sum, decode and output register.
`timescale 1ns / 1ps

module pod_dp #(
	parameter int unsigned MAX_ID_SIZE = 32,
	parameter int unsigned MAX_KEYS    = 6
) (
	input  logic                clk,
	input  logic                arst_n,
	input  pod_pkg::ctrl_word_t cw,
	output pod_pkg::dp_status_t st,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_wdata,
	input  logic                s_valid,
	input  pod_pkg::char_t      s_char,
	input  logic                s_last,
	input  logic                s_empty,
	output logic                m_valid,
	input  logic                m_ready,
	output pod_pkg::char_t      m_char,
	output logic                m_char_valid,
	output logic                m_last,
	output logic                m_status
);

	localparam int unsigned BodyLen = MAX_ID_SIZE - 1;
	localparam int unsigned PosCap  = MAX_ID_SIZE + MAX_KEYS;
	localparam int unsigned PosW    = $clog2(PosCap + 1);
	localparam int unsigned KtW     = $clog2(MAX_KEYS + 1);
	localparam int unsigned KeyAw   = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
	localparam int unsigned BodyAw  = $clog2(BodyLen);
	localparam int unsigned KcW     = (KtW > 3) ? KtW : 3;
	localparam int unsigned IdxW    = BodyAw + 3;

	// Configuration and load state
	logic [2:0]        key_count_q;
	logic [PosW-1:0]   pos_q;
	logic [KtW-1:0]    kt_q;
	logic [KeyAw-1:0]  ph_q [MAX_KEYS];
	logic              single_q;
	logic              single_status_q;

	// Stores
	pod_pkg::char_t    key_mem  [MAX_KEYS];
	pod_pkg::char_t    body_mem [BodyLen];
	pod_pkg::char_t    body_rd_q;
	pod_pkg::char_t    keya_rd_q;
	pod_pkg::char_t    keyb_rd_q;
	logic              keyb_ok_q;

	// Decode state
	logic [BodyAw-1:0] i_q;
	logic [2:0]        rem_q;
	logic [BodyAw-1:0] q_q;
	pod_pkg::char_t    prefix_q;
	pod_pkg::char_t    d_q;
	logic              hit_q;
	logic              lastc_q;
	logic              pend_valid_q;
	pod_pkg::char_t    pend_char_q;

	// Output register
	logic              out_valid_q;
	pod_pkg::char_t    out_char_q;
	logic              out_cv_q;
	logic              out_last_q;
	logic              out_status_q;

	logic              exec;
	logic              acc;
	logic              kvalid;
	logic [KeyAw-1:0]  kidx;
	logic              key_take;
	logic [PosW-1:0]   b_idx;
	logic              body_we;
	logic [PosW-1:0]   pos_nx;
	logic [KtW-1:0]    kt_nx;
	logic              len_ok;
	logic [7:0]        sum_a;
	logic [7:0]        sum_b;
	pod_pkg::char_t    rk;
	pod_pkg::char_t    kvb;
	pod_pkg::char_t    d;
	pod_pkg::char_t    prefix_nx;
	logic [7:0]        body8;
	logic [7:0]        rk8;
	logic              rem_wrap;
	logic              load_out;

	// Step execution and input acceptance
	assign exec   = !(cw.wait_out && out_valid_q && !m_ready);
	assign acc    = s_valid && cw.in_ready;
	assign kvalid = (key_count_q != 3'd0) && (KcW'(key_count_q) <= KcW'(MAX_KEYS));
	assign kidx   = KeyAw'(key_count_q - 3'd1);

	// Sort the incoming item into key or body
	assign key_take = kvalid && (KcW'(kt_q) < KcW'(key_count_q)) &&
		(kt_q < KtW'(MAX_KEYS)) && (ph_q[kidx] == '0);
	assign b_idx    = pos_q - PosW'(kt_q);
	assign body_we  = !key_take && (pos_q >= PosW'(kt_q)) && (b_idx < PosW'(BodyLen));
	assign pos_nx   = (pos_q < PosW'(PosCap)) ? pos_q + PosW'(1) : pos_q;
	assign kt_nx    = key_take ? kt_q + KtW'(1) : kt_q;
	assign len_ok   = kvalid && (pos_nx == PosW'(BodyLen) + PosW'(key_count_q)) &&
		(KcW'(kt_nx) == KcW'(key_count_q));

	// Status toward the sequencer
	assign st.fin    = acc && (s_last || s_empty);
	assign st.single = single_q;
	assign st.hit    = hit_q;
	assign st.lastc  = lastc_q;
	assign st.obusy  = out_valid_q && !m_ready;

	// Hold the key count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_count_q <= 3'd6;
		end else if (cfg_we) begin
			key_count_q <= cfg_wdata;
		end
	end

	// Count positions, keys and per-modulus phases during load
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q           <= '0;
			kt_q            <= '0;
			single_q        <= 1'b0;
			single_status_q <= 1'b0;
			for (int j = 0; j < MAX_KEYS; j++) begin
				ph_q[j] <= '0;
			end
		end else if (acc) begin
			if (s_empty || s_last) begin
				pos_q           <= '0;
				kt_q            <= '0;
				single_q        <= s_empty || !len_ok;
				single_status_q <= s_empty ? !kvalid : 1'b1;
				for (int j = 0; j < MAX_KEYS; j++) begin
					ph_q[j] <= '0;
				end
			end else begin
				pos_q <= pos_nx;
				kt_q  <= kt_nx;
				if (pos_q < PosW'(PosCap)) begin
					for (int j = 0; j < MAX_KEYS; j++) begin
						ph_q[j] <= (ph_q[j] == KeyAw'(j)) ? '0 : ph_q[j] + KeyAw'(1);
					end
				end
			end
		end
	end

	// Write the stores and read them for one body character
	always_ff @(posedge clk) begin
		if (acc && !s_empty && key_take) begin
			key_mem[kt_q[KeyAw-1:0]] <= pod_pkg::reduce_key(s_char);
		end
		if (acc && !s_empty && body_we) begin
			body_mem[b_idx[BodyAw-1:0]] <= s_char;
		end
		if (exec && cw.op == pod_pkg::OP_READ) begin
			body_rd_q <= body_mem[BodyAw'(BodyLen - 1) - i_q];
			keya_rd_q <= key_mem[rem_q[KeyAw-1:0]];
			keyb_rd_q <= key_mem[q_q[KeyAw-1:0]];
			keyb_ok_q <= IdxW'(q_q) < IdxW'(key_count_q);
		end
	end

	// Running key sum and subtract-and-wrap
	always_comb begin
		kvb       = keyb_ok_q ? keyb_rd_q : '0;
		sum_a     = {1'b0, prefix_q} + {1'b0, keya_rd_q};
		rk        = (sum_a >= pod_pkg::PRINT_RANGE) ?
			pod_pkg::CharW'(sum_a - pod_pkg::PRINT_RANGE) : sum_a[pod_pkg::CharW-1:0];
		sum_b     = {1'b0, prefix_q} + {1'b0, kvb};
		prefix_nx = (sum_b >= pod_pkg::PRINT_RANGE) ?
			pod_pkg::CharW'(sum_b - pod_pkg::PRINT_RANGE) : sum_b[pod_pkg::CharW-1:0];
		body8     = {1'b0, body_rd_q};
		rk8       = {1'b0, rk};
		if (body8 >= rk8 + pod_pkg::FIRST_PRINT) begin
			d = pod_pkg::CharW'(body8 - rk8);
		end else begin
			d = pod_pkg::CharW'(body8 + pod_pkg::PRINT_RANGE - rk8);
		end
		rem_wrap  = (rem_q + 3'd1) == key_count_q;
	end

	// Advance the decode index, key slot and prefix sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q          <= '0;
			rem_q        <= '0;
			q_q          <= '0;
			prefix_q     <= '0;
			hit_q        <= 1'b0;
			lastc_q      <= 1'b0;
			pend_valid_q <= 1'b0;
		end else if (exec) begin
			unique case (cw.op)
				pod_pkg::OP_INIT: begin
					i_q          <= '0;
					rem_q        <= '0;
					q_q          <= '0;
					prefix_q     <= '0;
					pend_valid_q <= 1'b0;
				end
				pod_pkg::OP_CALC: begin
					hit_q   <= d == pod_pkg::FIRST_PRINT[pod_pkg::CharW-1:0];
					lastc_q <= i_q == BodyAw'(BodyLen - 1);
					i_q     <= i_q + BodyAw'(1);
					if (rem_wrap) begin
						rem_q    <= '0;
						q_q      <= q_q + BodyAw'(1);
						prefix_q <= prefix_nx;
					end else begin
						rem_q <= rem_q + 3'd1;
					end
				end
				pod_pkg::OP_EMIT: begin
					pend_valid_q <= !hit_q;
				end
				default: begin
				end
			endcase
		end
	end

	// Hold decoded characters
	always_ff @(posedge clk) begin
		if (exec && cw.op == pod_pkg::OP_CALC) begin
			d_q <= d;
		end
		if (exec && cw.op == pod_pkg::OP_EMIT) begin
			pend_char_q <= d_q;
		end
	end

	// Load the output register; drop the item once taken
	assign load_out = exec && ((cw.op == pod_pkg::OP_EMIT && (pend_valid_q || hit_q)) ||
		cw.op == pod_pkg::OP_FLUSH || cw.op == pod_pkg::OP_SINGLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			priority if (cw.op == pod_pkg::OP_SINGLE) begin
				out_char_q   <= '0;
				out_cv_q     <= 1'b0;
				out_last_q   <= 1'b1;
				out_status_q <= single_status_q;
			end else if (cw.op == pod_pkg::OP_FLUSH || pend_valid_q) begin
				out_char_q   <= pend_char_q;
				out_cv_q     <= 1'b1;
				out_last_q   <= (cw.op == pod_pkg::OP_FLUSH) || hit_q;
				out_status_q <= 1'b0;
			end else begin
				out_char_q   <= '0;
				out_cv_q     <= 1'b0;
				out_last_q   <= 1'b1;
				out_status_q <= 1'b0;
			end
		end
	end

	assign m_valid      = out_valid_q;
	assign m_char       = out_char_q;
	assign m_char_valid = out_cv_q;
	assign m_last       = out_last_q;
	assign m_status     = out_status_q;

	// Load counters stay within their caps
	a_kt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		kt_q <= KtW'(MAX_KEYS))
		else $error("keys taken beyond key store depth");

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= PosW'(PosCap))
		else $error("position count beyond cap");

	// A single-item result goes out as a closing item without a character
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		exec && cw.op == pod_pkg::OP_SINGLE |=> out_valid_q && out_last_q && !out_cv_q)
		else $error("single result not loaded as closing item");

	// A terminator closes the result and leaves nothing pending
	a_hit: assert property (@(posedge clk) disable iff (!arst_n)
		exec && cw.op == pod_pkg::OP_EMIT && hit_q |=> out_valid_q && out_last_q &&
		!pend_valid_q)
		else $error("terminator did not close the result");

endmodule

// File: rtl/password_obfuscation_decoder.sv
// Top level of the password obfuscation decoder: stream ports, sequencer and datapath.
// Load: one character item per cycle; keys and body go to their stores as they arrive.
// Finish: an init step, then the read, compute, emit and branch steps of the microcode
// loop per decoded body character, and a flush step to close; a terminator ends the
// loop at its emit step. An error or an empty string goes from init to a single step.
// A stalled sink holds the emit, flush and single steps.
// Input is not taken while a string decodes; one output register decouples the sink.
// Reset (arst_n low): counters and handshakes clear, key count becomes 6; stores keep
// no reset value and are only read where written in the current string.
`timescale 1ns / 1ps

module password_obfuscation_decoder #(
	parameter int unsigned MAX_ID_SIZE = 32,
	parameter int unsigned MAX_KEYS    = 6
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [2:0] cfg_wdata,      // key_count
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [6:0] cipher_char, [7] zero
	input  logic       s_axis_tlast,   // final character of the string
	input  logic [0:0] s_axis_tuser,   // [0] empty_string
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [6:0] plain_char, [7] zero
	output logic       m_axis_tlast,   // end_of_result
	output logic [1:0] m_axis_tuser    // [0] char_valid, [1] status
);

	pod_pkg::ctrl_word_t cw;
	pod_pkg::dp_status_t st;
	pod_pkg::char_t      out_char;
	logic                out_cv;
	logic                out_status;

	pod_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.st     (st),
		.cw     (cw)
	);

	pod_dp #(
		.MAX_ID_SIZE (MAX_ID_SIZE),
		.MAX_KEYS    (MAX_KEYS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cw           (cw),
		.st           (st),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.s_valid      (s_axis_tvalid),
		.s_char       (s_axis_tdata[6:0]),
		.s_last       (s_axis_tlast),
		.s_empty      (s_axis_tuser[0]),
		.m_valid      (m_axis_tvalid),
		.m_ready      (m_axis_tready),
		.m_char       (out_char),
		.m_char_valid (out_cv),
		.m_last       (m_axis_tlast),
		.m_status     (out_status)
	);

	// Take items only in the load step
	assign s_axis_tready = cw.in_ready;
	assign m_axis_tdata  = {1'b0, out_char};
	assign m_axis_tuser  = {out_status, out_cv};

endmodule

// File: test/password_obfuscation_decoder_checker.sv
// Checker for the password decoder: predicts decoded items from accepted input and compares.
`timescale 1ns / 1ps

module password_obfuscation_decoder_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [2:0] cfg_wdata,
	input  logic       s_axis_tvalid,
	input  logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [6:0] cipher_char, [7] zero
	input  logic       s_axis_tlast,   // final character of the string
	input  logic [0:0] s_axis_tuser,   // [0] empty_string
	input  logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	input  logic [7:0] m_axis_tdata,   // [6:0] plain_char, [7] zero
	input  logic       m_axis_tlast,   // end_of_result
	input  logic [1:0] m_axis_tuser,   // [0] char_valid, [1] status
	output int         fail_count,
	output int         pending,
	output int         results_seen
);

	localparam int BodyLen   = 31;
	localparam int KeySlots  = 6;
	localparam int PosCap    = 38;
	localparam int FirstCode = int'(pod_pkg::FIRST_PRINT);
	localparam int CodeSpan  = int'(pod_pkg::PRINT_RANGE);
	localparam logic StatusOk  = 1'b0;
	localparam logic StatusBad = 1'b1;

	typedef struct packed {
		pod_pkg::char_t plain;
		logic           valid;
		logic           eor;
		logic           status;
	} plain_item_t;

	pod_pkg::char_t key_chars [KeySlots];
	pod_pkg::char_t body_chars [BodyLen];
	int             chars_seen;
	int             keys_seen;
	int             key_count;
	int             fails;
	int             seen;
	plain_item_t    decoded_q [$];

	// Key value of one slot; slots not taken in this string count as zero
	function automatic int key_weight(input int slot);
		if (slot >= key_count || slot >= keys_seen || slot >= KeySlots) begin
			return 0;
		end
		return (int'(key_chars[slot]) + CodeSpan - FirstCode) % CodeSpan;
	endfunction

	// Running key sum subtracted from decoded position i
	function automatic int running_key(input int i);
		int sum;
		int q;
		sum = 0;
		q = i / key_count;
		for (int j = 0; j < q; j++) begin
			sum += key_weight(j);
		end
		sum += key_weight(i % key_count);
		return sum % CodeSpan;
	endfunction

	task automatic push_result(input pod_pkg::char_t c, input logic v, input logic e,
		input logic s);
		plain_item_t item;
		item.plain = c;
		item.valid = v;
		item.eor = e;
		item.status = s;
		decoded_q.push_back(item);
	endtask

	// Advance the decoder state by one accepted character item
	task automatic take_char(input pod_pkg::char_t c, input logic last, input logic empty);
		logic           kvalid;
		logic           ok;
		int             d;
		int             n;
		int             b;
		pod_pkg::char_t plain [BodyLen];
		kvalid = key_count >= 1 && key_count <= KeySlots;
		if (empty) begin
			chars_seen = 0;
			keys_seen = 0;
			push_result('0, 1'b0, 1'b1, kvalid ? StatusOk : StatusBad);
			return;
		end

		// store as key or as body character
		if (kvalid && keys_seen < key_count && keys_seen < KeySlots &&
			chars_seen % key_count == 0) begin
			key_chars[keys_seen] = c;
			keys_seen++;
		end else if (chars_seen >= keys_seen) begin
			b = chars_seen - keys_seen;
			if (b < BodyLen) begin
				body_chars[b] = c;
			end
		end
		if (chars_seen < PosCap) begin
			chars_seen++;
		end
		if (!last) begin
			return;
		end

		ok = kvalid && chars_seen == BodyLen + key_count && keys_seen == key_count;
		if (!ok) begin
			chars_seen = 0;
			keys_seen = 0;
			push_result('0, 1'b0, 1'b1, StatusBad);
			return;
		end

		// reverse the body, subtract the running key, stop at the first '!'
		n = 0;
		for (int i = 0; i < BodyLen; i++) begin
			d = int'(body_chars[BodyLen - 1 - i]) - running_key(i);
			if (d < FirstCode) begin
				d += CodeSpan;
			end
			if (d == FirstCode) begin
				break;
			end
			plain[n] = pod_pkg::char_t'(d);
			n++;
		end
		chars_seen = 0;
		keys_seen = 0;
		if (n == 0) begin
			push_result('0, 1'b0, 1'b1, StatusOk);
		end else begin
			for (int i = 0; i < n; i++) begin
				push_result(plain[i], 1'b1, i == n - 1, StatusOk);
			end
		end
	endtask

	// Compare one accepted result item with the oldest prediction
	task automatic check_result();
		plain_item_t want;
		seen++;
		if (decoded_q.size() == 0) begin
			$error({"unexpected result item: plain_char %0d char_valid %0b ",
				"end_of_result %0b status %0b"},
				m_axis_tdata, m_axis_tuser[0], m_axis_tlast, m_axis_tuser[1]);
			fails++;
			return;
		end
		want = decoded_q.pop_front();
		if (m_axis_tdata !== {1'b0, want.plain}) begin
			$error("plain_char: expected %0d, got %0d", want.plain, m_axis_tdata);
			fails++;
		end
		if (m_axis_tuser[0] !== want.valid) begin
			$error("char_valid: expected %0b, got %0b", want.valid, m_axis_tuser[0]);
			fails++;
		end
		if (m_axis_tlast !== want.eor) begin
			$error("end_of_result: expected %0b, got %0b", want.eor, m_axis_tlast);
			fails++;
		end
		if (m_axis_tuser[1] !== want.status) begin
			$error("status: expected %0b, got %0b", want.status, m_axis_tuser[1]);
			fails++;
		end
	endtask

	// Watch both channels and the register port; an item taken at a write edge
	// still sees the old key count
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_count = 6;
			chars_seen = 0;
			keys_seen = 0;
			fails = 0;
			seen = 0;
			decoded_q.delete();
			pending <= 0;
			fail_count <= 0;
			results_seen <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				take_char(s_axis_tdata[6:0], s_axis_tlast, s_axis_tuser[0]);
			end
			if (cfg_we) begin
				key_count = int'(cfg_wdata);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				check_result();
			end
			pending <= decoded_q.size();
			fail_count <= fails;
			results_seen <= seen;
		end
	end

endmodule

// File: test/password_obfuscation_decoder_test.sv
// Testbench top for the password decoder: clock, reset, stimulus, sink pacing and verdict.
`timescale 1ns / 1ps

module password_obfuscation_decoder_test;

	localparam int HalfPeriod    = 6;
	localparam int ResetCycles   = 11;
	localparam int IdlePct       = 11;
	localparam int HoldOffCycles = 700;
	localparam int WatchdogLimit = 5000;
	localparam int RandomItems   = 160;
	localparam int SettleCycles  = 12;
	localparam int DrainCycles   = 200;
	localparam int BodyLen       = 31;
	localparam int FirstCode     = int'(pod_pkg::FIRST_PRINT);
	localparam int CodeSpan      = int'(pod_pkg::PRINT_RANGE);

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [2:0] cfg_wdata;
	logic       s_axis_tvalid;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata;   // [6:0] cipher_char, [7] zero
	logic       s_axis_tlast;   // final character of the string
	logic [0:0] s_axis_tuser;   // [0] empty_string
	logic       m_axis_tvalid;
	logic       m_axis_tready;
	logic [7:0] m_axis_tdata;   // [6:0] plain_char, [7] zero
	logic       m_axis_tlast;   // end_of_result
	logic [1:0] m_axis_tuser;   // [0] char_valid, [1] status

	int fail_count;
	int pending;
	int results_seen;

	bit steady;
	bit hold_off_req;
	int cur_keys;
	int items_sent;
	int strings_sent;
	int strings_good;
	int cfg_writes;

	password_obfuscation_decoder dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	password_obfuscation_decoder_checker decode_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser),
		.fail_count    (fail_count),
		.pending       (pending),
		.results_seen  (results_seen)
	);

	initial begin
		clk = 1'b0;
		forever #HalfPeriod clk = ~clk;
	end

	// Offer one item, with random gaps, and hold it until accepted
	task automatic send_item(input pod_pkg::char_t c, input logic last, input logic empty);
		while (!steady && $urandom_range(99) < IdlePct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {1'b0, c};
		s_axis_tlast <= last;
		s_axis_tuser <= empty;
		do @(posedge clk); while (!s_axis_tready);
		items_sent++;
		if (last || empty) begin
			strings_sent++;
		end
	endtask

	// Drain all results, let the block settle, then write the key count
	task automatic set_key_count(input int k);
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SettleCycles) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= 3'(k);
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_keys = k;
		cfg_writes++;
	endtask

	// Random characters, mostly printable; last flag on the final one if asked
	task automatic send_noise(input int len, input logic with_last);
		pod_pkg::char_t c;
		for (int n = 0; n < len; n++) begin
			c = ($urandom_range(9) == 0) ? pod_pkg::char_t'($urandom_range(127))
				: pod_pkg::char_t'($urandom_range(126, 33));
			send_item(c, with_last && n == len - 1, 1'b0);
		end
	endtask

	// Encode a random password of pw_len characters under the current key count;
	// wild replaces some characters with arbitrary 7-bit codes
	task automatic send_encoded(input int pw_len, input bit wild);
		int             kv [6];
		int             plain [BodyLen];
		pod_pkg::char_t body [BodyLen];
		int             k;
		int             sum;
		int             kt;
		int             bi;
		pod_pkg::char_t c;
		k = cur_keys;
		for (int s = 0; s < k; s++) begin
			kv[s] = $urandom_range(CodeSpan - 1);
		end
		for (int i = 0; i < BodyLen; i++) begin
			if (i < pw_len) begin
				plain[i] = $urandom_range(126, FirstCode + 1);
			end else if (i == pw_len) begin
				plain[i] = FirstCode;
			end else begin
				plain[i] = $urandom_range(126, FirstCode);
			end
		end
		// add the running key and reverse
		for (int i = 0; i < BodyLen; i++) begin
			sum = kv[i % k];
			for (int j = 0; j < i / k && j < k; j++) begin
				sum += kv[j];
			end
			body[BodyLen - 1 - i] =
				pod_pkg::char_t'((plain[i] - FirstCode + sum) % CodeSpan + FirstCode);
		end
		// interleave keys at positions 0, K, 2K, ...
		kt = 0;
		bi = 0;
		for (int pos = 0; pos < BodyLen + k; pos++) begin
			if (pos % k == 0 && kt < k) begin
				c = pod_pkg::char_t'(kv[kt] + FirstCode);
				kt++;
			end else begin
				c = body[bi];
				bi++;
			end
			if (wild && $urandom_range(9) == 0) begin
				c = pod_pkg::char_t'($urandom_range(127));
			end
			send_item(c, pos == BodyLen + k - 1, 1'b0);
		end
		if (!wild) begin
			strings_good++;
		end
	endtask

	// Sink pacing: random stalls, one long hold-off on request, none while steady
	initial begin
		bit held;
		held = 1'b0;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off_req && !held) begin
				m_axis_tready <= 1'b0;
				repeat (HoldOffCycles) @(posedge clk);
				held = 1'b1;
			end else begin
				m_axis_tready <= steady || $urandom_range(99) >= IdlePct;
			end
		end
	end

	// Watchdog: end the run if no item moves on either side for too long
	initial begin
		int quiet;
		quiet = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
			if (quiet >= WatchdogLimit) begin
				$display("Watchdog: no item moved for %0d cycles, %0d results outstanding",
					quiet, pending);
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	// Stimulus
	initial begin
		int stop_at;
		int r;
		int len;
		int strings;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tlast = 1'b0;
		s_axis_tuser = '0;
		cur_keys = 6;
		items_sent = 0;
		strings_sent = 0;
		strings_good = 0;
		cfg_writes = 0;
		repeat (ResetCycles) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty strings, with and without the last flag
		send_item(7'd0, 1'b0, 1'b1);
		send_item(7'h7f, 1'b1, 1'b1);
		// one-character string: wrong length
		send_item(7'd33, 1'b1, 1'b0);
		// partial string dropped by an empty string
		send_item(7'd126, 1'b0, 1'b0);
		send_item(7'd64, 1'b0, 1'b0);
		send_item(7'd90, 1'b0, 1'b1);
		// invalid key counts: every string reports an error
		set_key_count(0);
		send_item(7'd50, 1'b1, 1'b0);
		send_item(7'd0, 1'b0, 1'b1);
		set_key_count(7);
		send_item(7'h7f, 1'b0, 1'b0);
		send_item(7'd32, 1'b1, 1'b0);
		send_item(7'd45, 1'b1, 1'b1);
		// key count changed in the middle of a short string
		set_key_count(2);
		send_item(7'd33, 1'b0, 1'b0);
		send_item(7'd40, 1'b0, 1'b0);
		send_item(7'd126, 1'b0, 1'b0);
		set_key_count(4);
		send_item(7'd32, 1'b0, 1'b0);
		send_item(7'd1, 1'b1, 1'b0);

		// full strings at both key count extremes: empty and longest passwords
		set_key_count(1);
		send_encoded(0, 1'b0);
		send_encoded(31, 1'b0);
		set_key_count(6);
		send_encoded(0, 1'b0);
		send_encoded(31, 1'b0);
		send_encoded(12, 1'b1);
		// over-long string saturates the position counter
		send_noise(45, 1'b1);
		// right length after lowering the key count, but too many keys taken
		set_key_count(2);
		send_noise(3, 1'b0);
		set_key_count(1);
		send_noise(29, 1'b1);

		// random strings, mostly well formed
		stop_at = items_sent + RandomItems;
		strings = 0;
		while (items_sent < stop_at) begin
			if (strings % 4 == 0) begin
				r = $urandom_range(19);
				set_key_count(r == 0 ? 0 : r == 1 ? 7 : $urandom_range(6, 1));
			end
			if (strings == 1) begin
				hold_off_req <= 1'b1;
			end
			if (strings == 2) begin
				steady <= 1'b1;
			end else if (strings == 4) begin
				steady <= 1'b0;
			end
			r = $urandom_range(99);
			len = $urandom_range(9);
			len = len == 0 ? 0 : len == 1 ? 31 : $urandom_range(30, 1);
			if (cur_keys < 1 || cur_keys > 6) begin
				if (r < 40) begin
					send_item(pod_pkg::char_t'($urandom_range(127)), 1'($urandom_range(1)),
						1'b1);
				end else begin
					send_noise($urandom_range(12, 1), 1'b1);
				end
			end else if (r < 70) begin
				send_encoded(len, 1'b0);
			end else if (r < 78) begin
				send_encoded(len, 1'b1);
			end else if (r < 86) begin
				send_item(pod_pkg::char_t'($urandom_range(127)), 1'($urandom_range(1)), 1'b1);
			end else begin
				send_noise($urandom_range(45, 1), 1'($urandom_range(1)));
			end
			strings++;
		end

		// close out: wait for every result, then let the block go quiet
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (DrainCycles) @(posedge clk);
		$display("Sent %0d strings (%0d cleanly encoded) in %0d items over %0d key count writes",
			strings_sent, strings_good, items_sent, cfg_writes);
		$display("Checked %0d result items with stalls on both sides and one long sink hold-off",
			results_seen);
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

// File: password_obfuscation_decoder.f
rtl/pod_pkg.sv
rtl/pod_seq.sv
rtl/pod_dp.sv
rtl/password_obfuscation_decoder.sv
test/password_obfuscation_decoder_checker.sv
test/password_obfuscation_decoder_test.sv
